>>> src/generational_slot_allocator_top_defines.svh
// assertion macros shared by the slot allocator rtl
`ifndef GENERATIONAL_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_TOP_DEFINES_SVH

// property that must hold in every cycle out of reset
`define GSA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define GSA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/gsa_pkg.sv
// shared types and codes of the slot allocator
package gsa_pkg;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned IDX_IN_W = 8;
  localparam int unsigned GEN_IN_W = 16;
  localparam int unsigned STATUS_W = 2;

  // request modes
  localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHECK  = 2'd2;

  // response status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [IDX_IN_W-1:0] slot_index;
    logic [GEN_IN_W-1:0] handle_generation;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_IN_W-1:0] result_index;
    logic [GEN_IN_W-1:0] result_generation;
    logic                handle_valid;
  } rsp_t;

endpackage

>>> src/gsa_stream_if.sv
// valid/ready stream interface carrying one payload
interface gsa_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> src/gsa_ram.sv
// generic single write port ram with registered read
module gsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

>>> src/generational_slot_allocator_top.sv
// Generational slot allocator: hands out slot handles (index plus generation),
// removes them and checks them. Every slot keeps its generation, active flag and
// free-list link in one entry of a single-port-read memory. A request is read
// from memory in the cycle after it is taken, then decided, written back and
// placed in the output register. No new request is taken while one is held
// before the output register, which it can only enter once that is drained.
// A pending response in the output register does not block taking the next
// request. The count of slots ever used doubles as a fill mark, so the memory
// needs no clearing pass after reset and the block is ready right after reset.
`include "generational_slot_allocator_top_defines.svh"

module generational_slot_allocator_top #(
  parameter int unsigned SLOT_COUNT = 256,
  parameter int unsigned GEN_BITS   = 16
) (
  input logic           clk_i,
  input logic           rst_ni,
  gsa_stream_if.sink    req_i,
  gsa_stream_if.source  rsp_o
);
  import gsa_pkg::*;

  localparam int unsigned IDX_W   = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W   = $clog2(SLOT_COUNT + 1);
  localparam int unsigned CMP_W   = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;
  localparam int unsigned GCMP_W  = (GEN_BITS > GEN_IN_W) ? GEN_BITS : GEN_IN_W;
  localparam int unsigned ENTRY_W = 2 + IDX_W + GEN_BITS;
  localparam logic [CNT_W-1:0] SLOTS_FULL = CNT_W'(SLOT_COUNT);

  typedef struct packed {
    logic                active;
    logic                link_end;
    logic [IDX_W-1:0]    link;
    logic [GEN_BITS-1:0] gen;
  } entry_t;

  // pipeline and free list state
  logic                s1_valid_q;
  req_t                s1_req_q;
  logic                out_valid_q;
  rsp_t                out_q, out_d;
  logic [IDX_W-1:0]    head_q, head_d;
  logic                nonempty_q, nonempty_d;
  logic [CNT_W-1:0]    used_q, used_d;

  logic                req_fire, s1_fire;
  logic [CMP_W-1:0]    req_idx_ext;
  logic [IDX_W-1:0]    rd_addr;
  logic [ENTRY_W-1:0]  rd_data;
  entry_t              rd_entry;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  entry_t              mem_wentry;

  logic [CMP_W-1:0]    s1_idx_ext;
  logic [IDX_W-1:0]    s1_idx;
  logic                in_range, gen_match, handle_ok;
  logic [CMP_W-1:0]    head_ext, used_ext;
  logic [GCMP_W-1:0]   rd_gen_ext, req_gen_ext;

  logic                rsp_full, rsp_handle_ok, table_spent, head_below_used;

  // request side: one request in flight
  assign req_fire    = req_i.valid && req_i.ready;
  assign req_i.ready = !s1_valid_q;
  assign req_idx_ext = CMP_W'(req_i.payload.slot_index);
  assign rd_addr     = (req_i.payload.mode == MODE_ALLOC) ? head_q : req_idx_ext[IDX_W-1:0];

  gsa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wentry),
    .re_i    (req_fire),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign rd_entry = entry_t'(rd_data);
  assign s1_fire  = s1_valid_q && (!out_valid_q || rsp_o.ready);

  // handle check against the entry read back
  assign s1_idx_ext  = CMP_W'(s1_req_q.slot_index);
  assign s1_idx      = s1_idx_ext[IDX_W-1:0];
  assign used_ext    = CMP_W'(used_q);
  assign in_range    = s1_idx_ext < used_ext;
  assign rd_gen_ext  = GCMP_W'(rd_entry.gen);
  assign req_gen_ext = GCMP_W'(s1_req_q.handle_generation);
  assign gen_match   = rd_gen_ext == req_gen_ext;
  assign handle_ok   = in_range && rd_entry.active && gen_match;
  assign head_ext    = CMP_W'(head_q);

  // decide, build write back and response
  always_comb begin
    head_d     = head_q;
    nonempty_d = nonempty_q;
    used_d     = used_q;
    mem_we     = 1'b0;
    mem_waddr  = s1_idx;
    mem_wentry = rd_entry;
    out_d.status            = ST_OK;
    out_d.result_index      = s1_req_q.slot_index;
    out_d.result_generation = s1_req_q.handle_generation;
    out_d.handle_valid      = 1'b0;
    if (s1_req_q.mode == MODE_ALLOC) begin
      if (nonempty_q) begin
        // reuse the most recently freed slot
        mem_we            = s1_fire;
        mem_waddr         = head_q;
        mem_wentry.active = 1'b1;
        head_d            = rd_entry.link;
        nonempty_d        = !rd_entry.link_end;
        out_d.result_index      = head_ext[IDX_IN_W-1:0];
        out_d.result_generation = rd_gen_ext[GEN_IN_W-1:0];
      end else if (used_q != SLOTS_FULL) begin
        // fresh slot, generation starts at zero
        mem_we              = s1_fire;
        mem_waddr           = used_q[IDX_W-1:0];
        mem_wentry.active   = 1'b1;
        mem_wentry.link_end = 1'b0;
        mem_wentry.link     = '0;
        mem_wentry.gen      = '0;
        used_d              = used_q + 1'b1;
        out_d.result_index      = used_ext[IDX_IN_W-1:0];
        out_d.result_generation = '0;
      end else begin
        out_d.status = ST_FULL;
      end
    end else begin
      out_d.handle_valid = handle_ok;
      out_d.status       = handle_ok ? ST_OK : ST_INVALID;
      if ((s1_req_q.mode == MODE_REMOVE) && handle_ok) begin
        // retire handle and push slot on the free list
        mem_we              = s1_fire;
        mem_wentry.active   = 1'b0;
        mem_wentry.link_end = !nonempty_q;
        mem_wentry.link     = head_q;
        mem_wentry.gen      = rd_entry.gen + 1'b1;
        head_d              = s1_idx;
        nonempty_d          = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      head_q      <= '0;
      nonempty_q  <= 1'b0;
      used_q      <= '0;
    end else begin
      if (req_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
        head_q      <= head_d;
        nonempty_q  <= nonempty_d;
        used_q      <= used_d;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s1_req_q <= req_i.payload;
    end
    if (s1_fire) begin
      out_q <= out_d;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  // terms for the consistency checks
  assign rsp_full        = out_valid_q && (out_q.status == ST_FULL);
  assign rsp_handle_ok   = out_valid_q && out_q.handle_valid;
  assign table_spent     = (used_q == SLOTS_FULL) && !nonempty_q;
  assign head_below_used = CNT_W'(head_q) < used_q;

  // consistency checks
  `GSA_ASSERT(a_used_bound, used_q <= SLOTS_FULL, "slot count beyond table size")
  `GSA_ASSERT(a_head_in_use, !nonempty_q || head_below_used, "free head never used")
  `GSA_ASSERT(a_full_exhausted, !rsp_full || table_spent, "full reported with slots left")
  `GSA_ASSERT(a_valid_is_ok, !rsp_handle_ok || (out_q.status == ST_OK), "valid handle, bad status")
  `GSA_ASSERT_NEXT(a_accept_loads, req_fire, s1_valid_q, "accepted request lost")

endmodule

>>> sim/slot_table_checker.sv
// checker for the slot allocator: predicts every response and compares it
module slot_table_checker
  import gsa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  logic req_ready_i,
  input  req_t req_payload_i,
  input  logic rsp_valid_i,
  input  logic rsp_ready_i,
  input  rsp_t rsp_payload_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   granted_o,
  output int   refused_o,
  output int   freed_o,
  output int   rejected_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOT_COUNT = 256;

  // shadow of the slot table
  logic [GEN_IN_W-1:0] slot_gen  [SLOT_COUNT];
  bit                  slot_live [SLOT_COUNT];
  logic [7:0]          free_link [SLOT_COUNT];
  bit                  link_last [SLOT_COUNT];
  logic [7:0]          free_top;
  bit                  free_any;
  logic [8:0]          slots_touched;

  rsp_t awaited_rsp[$];

  // apply one request to the shadow table and return its response
  function automatic rsp_t apply_slot_request(req_t r);
    rsp_t       o;
    logic [7:0] slot;
    bit         ok;
    o.status            = ST_OK;
    o.result_index      = r.slot_index;
    o.result_generation = r.handle_generation;
    o.handle_valid      = 1'b0;
    slot                = '0;
    if (r.mode == MODE_ALLOC) begin
      if (free_any) begin
        // reuse the most recently freed slot
        slot     = free_top;
        free_any = !link_last[slot];
        free_top = free_link[slot];
      end else if (slots_touched < SLOT_COUNT) begin
        slot          = slots_touched[7:0];
        slots_touched = slots_touched + 9'd1;
      end else begin
        o.status = ST_FULL;
      end
      if (o.status == ST_OK) begin
        slot_live[slot]     = 1'b1;
        o.result_index      = slot;
        o.result_generation = slot_gen[slot];
        granted_o++;
      end else begin
        refused_o++;
      end
    end else begin
      // remove, check and the spare mode all test the handle first
      ok = (r.slot_index < slots_touched) && slot_live[r.slot_index] &&
           (slot_gen[r.slot_index] == r.handle_generation);
      o.handle_valid = ok;
      o.status       = ok ? ST_OK : ST_INVALID;
      if (!ok) rejected_o++;
      if (r.mode == MODE_REMOVE && ok) begin
        slot_live[r.slot_index] = 1'b0;
        slot_gen[r.slot_index]  = slot_gen[r.slot_index] + 1'b1;
        free_link[r.slot_index] = free_top;
        link_last[r.slot_index] = !free_any;
        free_top                = r.slot_index;
        free_any                = 1'b1;
        freed_o++;
      end
    end
    return o;
  endfunction

  // responses are checked before the request of the same edge is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_gen[i]  = '0;
        slot_live[i] = 1'b0;
      end
      free_top      = '0;
      free_any      = 1'b0;
      slots_touched = '0;
      awaited_rsp.delete();
      fail_count_o  = 0;
      pending_o     = 0;
      granted_o     = 0;
      refused_o     = 0;
      freed_o       = 0;
      rejected_o    = 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (awaited_rsp.size() == 0) begin
          $error("response with no request outstanding: %p", rsp_payload_i);
          fail_count_o++;
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp_payload_i.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, rsp_payload_i.status);
            fail_count_o++;
          end
          if (rsp_payload_i.result_index !== want.result_index) begin
            $error("result_index expected %0d got %0d",
                   want.result_index, rsp_payload_i.result_index);
            fail_count_o++;
          end
          if (rsp_payload_i.result_generation !== want.result_generation) begin
            $error("result_generation expected %0d got %0d",
                   want.result_generation, rsp_payload_i.result_generation);
            fail_count_o++;
          end
          if (rsp_payload_i.handle_valid !== want.handle_valid) begin
            $error("handle_valid expected %0d got %0d",
                   want.handle_valid, rsp_payload_i.handle_valid);
            fail_count_o++;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        awaited_rsp.insert(awaited_rsp.size(), apply_slot_request(req_payload_i));
      end
      pending_o = awaited_rsp.size();
    end
  end

endmodule

>>> sim/testbench.sv
// top of the slot allocator testbench: clock, reset, request stimulus and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gsa_pkg::*;

  localparam int RESET_CYCLES   = 5;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RX_HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES  = 8;
  localparam int IDLE_PCT       = 33;

  // mode value the block treats like a check
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [IDX_IN_W-1:0] idx;
    logic [GEN_IN_W-1:0] gen;
  } handle_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  gsa_stream_if #(.T(req_t)) req_if ();
  gsa_stream_if #(.T(rsp_t)) rsp_if ();

  int fail_count, pending, granted, refused, freed, rejected;
  int requests_sent;

  // handles the block has handed out, used to build removes and checks
  handle_t          known_handles[$];
  logic [MODE_W-1:0] modes_in_flight[$];

  bit no_gaps;
  bit hold_rx;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  generational_slot_allocator_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  slot_table_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_if.valid),
    .req_ready_i   (req_if.ready),
    .req_payload_i (req_if.payload),
    .rsp_valid_i   (rsp_if.valid),
    .rsp_ready_i   (rsp_if.ready),
    .rsp_payload_i (rsp_if.payload),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .granted_o     (granted),
    .refused_o     (refused),
    .freed_o       (freed),
    .rejected_o    (rejected)
  );

  function automatic req_t make_req(logic [MODE_W-1:0] mode, logic [IDX_IN_W-1:0] idx,
                                    logic [GEN_IN_W-1:0] gen);
    req_t r;
    r.mode              = mode;
    r.slot_index        = idx;
    r.handle_generation = gen;
    return r;
  endfunction

  // offer one request after a random gap and wait until it is taken
  task automatic send_request(input req_t r);
    while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk_i); while (!req_if.ready);
    modes_in_flight.insert(modes_in_flight.size(), r.mode);
    requests_sent++;
  endtask

  // stop offering and wait until every response is back
  task automatic drain_responses();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  // one random request; what is left over after the three shares is noise
  task automatic send_random(input int alloc_pct, input int remove_pct, input int check_pct);
    int      roll;
    int      k;
    handle_t h;
    req_t    r;
    roll = $urandom_range(0, 99);
    r    = make_req(MODE_SPARE, IDX_IN_W'($urandom_range(0, 255)),
                    GEN_IN_W'($urandom_range(0, 65535)));
    r.mode = MODE_W'($urandom_range(0, 3));
    if (roll < alloc_pct) begin
      r.mode = MODE_ALLOC;
    end else if (roll < alloc_pct + remove_pct && known_handles.size() > 0) begin
      k = $urandom_range(0, known_handles.size() - 1);
      h = known_handles[k];
      known_handles.delete(k);
      r = make_req(MODE_REMOVE, h.idx, h.gen);
    end else if (roll < alloc_pct + remove_pct + check_pct && known_handles.size() > 0) begin
      k = $urandom_range(0, known_handles.size() - 1);
      h = known_handles[k];
      // now and then probe the next generation of a known slot
      if ($urandom_range(0, 7) == 0) h.gen = h.gen + 1'b1;
      r = make_req(MODE_CHECK, h.idx, h.gen);
    end
    send_request(r);
  endtask

  // collect the handles of granted allocations
  always @(posedge clk_i) begin
    logic [MODE_W-1:0] m;
    handle_t           h;
    if (rst_ni && rsp_if.valid && rsp_if.ready && modes_in_flight.size() > 0) begin
      m = modes_in_flight.pop_front();
      if (m == MODE_ALLOC && rsp_if.payload.status == ST_OK) begin
        h.idx = rsp_if.payload.result_index;
        h.gen = rsp_if.payload.result_generation;
        known_handles.insert(known_handles.size(), h);
      end
    end
  end

  // response side: random back-pressure plus one long hold-off on request
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        rsp_if.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        hold_rx = 1'b0;
      end else begin
        rsp_if.ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // stimulus and verdict
  initial begin
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    rst_ni         <= 1'b0;
    no_gaps        = 1'b0;
    hold_rx        = 1'b0;
    requests_sent  = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, first grants, stale and foreign handles, lifo reuse
    send_request(make_req(MODE_CHECK, 8'd0, 16'd0));
    send_request(make_req(MODE_REMOVE, 8'd0, 16'd0));
    send_request(make_req(MODE_ALLOC, 8'd0, 16'd0));
    send_request(make_req(MODE_ALLOC, 8'd0, 16'd0));
    send_request(make_req(MODE_ALLOC, 8'd0, 16'd0));
    send_request(make_req(MODE_CHECK, 8'd1, 16'd0));
    send_request(make_req(MODE_CHECK, 8'd1, 16'd1));
    send_request(make_req(MODE_CHECK, 8'd3, 16'd0));
    send_request(make_req(MODE_CHECK, 8'd255, 16'hffff));
    send_request(make_req(MODE_SPARE, 8'd2, 16'd0));
    send_request(make_req(MODE_REMOVE, 8'd1, 16'd0));
    send_request(make_req(MODE_REMOVE, 8'd1, 16'd0));
    send_request(make_req(MODE_CHECK, 8'd1, 16'd1));
    send_request(make_req(MODE_REMOVE, 8'd2, 16'd0));
    send_request(make_req(MODE_ALLOC, 8'd0, 16'd0));
    send_request(make_req(MODE_ALLOC, 8'd0, 16'd0));
    send_request(make_req(MODE_ALLOC, 8'd0, 16'd0));
    send_request(make_req(MODE_REMOVE, 8'd0, 16'd0));
    send_request(make_req(MODE_REMOVE, 8'd3, 16'd0));
    send_request(make_req(MODE_SPARE, 8'd0, 16'd1));
    send_request(make_req(MODE_REMOVE, 8'd255, 16'hffff));
    send_request(make_req(MODE_ALLOC, 8'hff, 16'hffff));
    send_request(make_req(MODE_ALLOC, 8'hff, 16'hffff));
    drain_responses();

    // fill the table past capacity so full refusals appear
    repeat (600) send_random(75, 15, 7);
    drain_responses();

    // free most of it, deep lifo chains
    repeat (400) send_random(20, 55, 20);
    drain_responses();

    // mixed traffic with a long response hold-off and a gap-free stretch
    for (int i = 0; i < 300; i++) begin
      if (i == 100) hold_rx = 1'b1;
      no_gaps = (i >= 150 && i < 230);
      send_random(40, 35, 20);
    end
    no_gaps = 1'b0;
    drain_responses();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("%0d requests: %0d slots granted, %0d full refusals, %0d handles freed,",
             requests_sent, granted, refused, freed);
    $display("%0d invalid handles rejected, %0d mismatches", rejected, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/gsa_pkg.sv
src/gsa_stream_if.sv
src/gsa_ram.sv
src/generational_slot_allocator_top.sv
sim/slot_table_checker.sv
sim/testbench.sv
